// ===== design/rte_pkg.sv =====
`timescale 1ns / 1ps
// Package of the row table engine: opcodes, micro-operations, and the
// command and status groups between controller and datapath. No dependencies.
package rte_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [3:0] {
    OP_APPEND = 4'd0,
    OP_COLUMN = 4'd1,
    OP_MAX    = 4'd2,
    OP_MIN    = 4'd3,
    OP_SEARCH = 4'd4,
    OP_COUNT  = 4'd5,
    OP_TOTAL  = 4'd6,
    OP_SORT   = 4'd7,
    OP_READ   = 4'd8,
    OP_RSV9   = 4'd9,
    OP_RSV10  = 4'd10,
    OP_RSV11  = 4'd11,
    OP_RSV12  = 4'd12,
    OP_RSV13  = 4'd13,
    OP_RSV14  = 4'd14,
    OP_RSV15  = 4'd15
  } op_e;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    U_NONE,
    U_START,
    U_APPEND,
    U_COLV,
    U_FILL,
    U_CCLR,
    U_RD,
    U_BEST,
    U_SRCH,
    U_TOT,
    U_LDC,
    U_SW,
    U_WEND,
    U_NEXT
  } uop_e;

  // Reset value of the fill register.
  localparam logic [31:0] FILL_RESET = 32'd999;

  typedef struct packed {
    logic capture;
    uop_e uop;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cend;
    logic empty;
    logic n_small;
    logic i_last;
    logic i_at_end;
    logic end_one;
    logic cur_full;
    logic tot_last;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/rte_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the row table engine: cell memory, fill counts, column cursor,
// scan and sort registers, and the result register. Depends on rte_pkg.
module rte_datapath #(
  parameter int NUM_ROWS     = 8,
  parameter int ROW_CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic [3:0]        opcode_i,
  input  logic [2:0]        row_i,
  input  logic [31:0]       value_i,
  input  logic              column_end_i,
  input  logic              ascending_i,
  input  rte_pkg::ctrl_cmd_t cmd_i,
  output rte_pkg::dp_stat_t  stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [31:0]       result_value_o,
  output logic [4:0]        result_index_o,
  output logic              found_o,
  output logic [8:0]        element_count_o,
  output logic              status_o,
  output logic              final_item_o
);
  import rte_pkg::*;

  localparam int RIW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int XW    = $clog2(ROW_CAPACITY);
  localparam int CW    = $clog2(ROW_CAPACITY + 1);
  localparam int CUW   = $clog2(NUM_ROWS + 1);
  localparam int DEPTH = NUM_ROWS * ROW_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] r,
                                               input logic [XW-1:0] c);
    return AW'(r) * AW'(ROW_CAPACITY) + AW'(c);
  endfunction

  // Latched item and configuration.
  op_e         op_q;
  logic [2:0]  row_q;
  logic [31:0] value_q, fill_q;
  logic        cend_q, asc_q;

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic [CW-1:0] cnt_q [NUM_ROWS];
  logic [CUW-1:0] cursor_q;
  logic [CW-1:0] i_q, end_q;
  logic [XW-1:0] idx_q;
  logic [31:0]   best_q, carry_q;
  logic          st_q, hit_q;
  logic [TW-1:0] tot_q;
  logic [RIW-1:0] tr_q;
  logic          out_valid_q;

  logic          row_valid;
  logic [RIW-1:0] row_ix;
  logic [CW-1:0] n;
  logic          out_free;

  assign row_valid = ({29'd0, row_q} < 32'(NUM_ROWS));
  assign row_ix    = RIW'(row_q);
  assign n         = row_valid ? cnt_q[row_ix] : '0;
  assign out_free  = !out_valid_q || out_ready_i;

  // Status toward the controller.
  always_comb begin
    stat_o.op       = op_q;
    stat_o.cend     = cend_q;
    stat_o.empty    = (n == '0);
    stat_o.n_small  = (n <= CW'(1));
    stat_o.i_last   = (CW'(i_q + CW'(1)) == n);
    stat_o.i_at_end = (i_q == end_q);
    stat_o.end_one  = (end_q == CW'(1));
    stat_o.cur_full = (cursor_q == CUW'(NUM_ROWS));
    stat_o.tot_last = (tr_q == RIW'(NUM_ROWS - 1));
    stat_o.match    = (rdata_q == value_q);
    stat_o.out_free = out_free;
  end

  // Shared push of one value to the end of a row.
  logic           push_en;
  logic [RIW-1:0] push_r;
  logic [31:0]    push_v;
  logic           push_full;

  always_comb begin
    push_en = 1'b0;
    push_r  = row_ix;
    push_v  = value_q;
    case (cmd_i.uop)
      U_APPEND: push_en = row_valid;
      U_COLV: begin
        push_en = (cursor_q < CUW'(NUM_ROWS));
        push_r  = RIW'(cursor_q);
      end
      U_FILL: begin
        push_en = 1'b1;
        push_r  = RIW'(cursor_q);
        push_v  = fill_q;
      end
      default: ;
    endcase
    push_full = (cnt_q[push_r] == CW'(ROW_CAPACITY));
  end

  // Sort compare: move the carried value past the element just read.
  logic swap;
  assign swap = asc_q ? ($signed(rdata_q) < $signed(carry_q))
                      : ($signed(carry_q) < $signed(rdata_q));

  logic take;
  assign take = (op_q == OP_MAX) ? ($signed(best_q) < $signed(rdata_q))
                                 : ($signed(rdata_q) < $signed(best_q));

  // Memory write port and read port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(push_r, cnt_q[push_r][XW-1:0]);
    mem_wdata = push_v;
    case (cmd_i.uop)
      U_APPEND, U_COLV, U_FILL: mem_we = push_en && !push_full;
      U_SW: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_ix, XW'(i_q - CW'(1)));
        mem_wdata = swap ? rdata_q : carry_q;
      end
      U_WEND: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_ix, end_q[XW-1:0]);
        mem_wdata = carry_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.uop == U_RD) begin
      rdata_q <= mem_q[cell_addr(row_ix, i_q[XW-1:0])];
    end
  end

  // Input capture and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FILL_RESET;
      op_q   <= OP_APPEND;
    end else begin
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        op_q <= op_e'(opcode_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q   <= row_i;
      value_q <= value_i;
      cend_q  <= column_end_i;
      asc_q   <= ascending_i;
    end
  end

  // Fill counts and column cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        cnt_q[k] <= '0;
      end
      cursor_q <= '0;
    end else begin
      if (push_en && !push_full) begin
        cnt_q[push_r] <= CW'(cnt_q[push_r] + CW'(1));
      end
      if (cmd_i.uop == U_COLV || cmd_i.uop == U_FILL) begin
        if (cursor_q < CUW'(NUM_ROWS)) begin
          cursor_q <= CUW'(cursor_q + CUW'(1));
        end
      end else if (cmd_i.uop == U_CCLR) begin
        cursor_q <= '0;
      end
    end
  end

  // Scan, total and sort working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.uop)
      U_START: begin
        i_q   <= '0;
        end_q <= CW'(n - CW'(1));
        st_q  <= 1'b0;
        hit_q <= 1'b0;
        idx_q <= '0;
        best_q <= '0;
        tot_q <= '0;
        tr_q  <= '0;
      end
      U_APPEND, U_COLV, U_FILL: begin
        if (push_en && push_full) begin
          st_q <= 1'b1;
        end
      end
      U_BEST: begin
        if (i_q == '0 || take) begin
          best_q <= rdata_q;
        end
        i_q <= CW'(i_q + CW'(1));
      end
      U_SRCH: begin
        if (rdata_q == value_q) begin
          hit_q <= 1'b1;
          idx_q <= i_q[XW-1:0];
        end
        i_q <= CW'(i_q + CW'(1));
      end
      U_TOT: begin
        tot_q <= TW'(tot_q + TW'(cnt_q[tr_q]));
        tr_q  <= RIW'(tr_q + RIW'(1));
      end
      U_LDC: begin
        carry_q <= rdata_q;
        i_q     <= CW'(1);
      end
      U_SW: begin
        if (!swap) begin
          carry_q <= rdata_q;
        end
        i_q <= CW'(i_q + CW'(1));
      end
      U_WEND: begin
        end_q <= CW'(end_q - CW'(1));
        i_q   <= '0;
      end
      U_NEXT: i_q <= CW'(i_q + CW'(1));
      default: ;
    endcase
  end

  // Result register; a new item loads only when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_value_o  <= '0;
      result_index_o  <= '0;
      found_o         <= 1'b0;
      element_count_o <= '0;
      status_o        <= 1'b0;
      final_item_o    <= 1'b1;
      case (op_q)
        OP_APPEND, OP_COLUMN: status_o <= st_q;
        OP_MAX, OP_MIN: result_value_o <= best_q;
        OP_SEARCH: begin
          result_index_o <= 5'(idx_q);
          found_o        <= hit_q;
        end
        OP_COUNT: element_count_o <= 9'(n);
        OP_TOTAL: element_count_o <= 9'(tot_q);
        OP_READ: begin
          if (n != '0) begin
            result_value_o <= rdata_q;
            found_o        <= 1'b1;
            final_item_o   <= (CW'(i_q + CW'(1)) == n);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/rte_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the row table engine: sequences each operation as datapath
// micro-operations. Depends on rte_pkg.
module rte_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rte_pkg::dp_stat_t  stat_i,
  output rte_pkg::ctrl_cmd_t cmd_o
);
  import rte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_APP, S_COL, S_FILL, S_RD, S_CMP, S_TOT,
    S_SRD0, S_SLD, S_SRDJ, S_SSW, S_SWE, S_RRD, S_REM, S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.uop     = U_NONE;
    cmd_o.emit    = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        cmd_o.uop = U_START;
        case (stat_i.op)
          OP_APPEND: state_d = S_APP;
          OP_COLUMN: state_d = S_COL;
          OP_MAX, OP_MIN, OP_SEARCH: state_d = stat_i.empty ? S_EMIT : S_RD;
          OP_COUNT:  state_d = S_EMIT;
          OP_TOTAL:  state_d = S_TOT;
          OP_SORT:   state_d = stat_i.n_small ? S_EMIT : S_SRD0;
          OP_READ:   state_d = stat_i.empty ? S_EMIT : S_RRD;
          default:   state_d = S_IDLE;
        endcase
      end
      S_APP: begin
        cmd_o.uop = U_APPEND;
        state_d   = S_EMIT;
      end
      S_COL: begin
        cmd_o.uop = U_COLV;
        state_d   = stat_i.cend ? S_FILL : S_EMIT;
      end
      S_FILL: begin
        if (stat_i.cur_full) begin
          cmd_o.uop = U_CCLR;
          state_d   = S_EMIT;
        end else begin
          cmd_o.uop = U_FILL;
        end
      end
      S_RD: begin
        cmd_o.uop = U_RD;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (stat_i.op == OP_SEARCH) begin
          cmd_o.uop = U_SRCH;
          state_d   = (stat_i.match || stat_i.i_last) ? S_EMIT : S_RD;
        end else begin
          cmd_o.uop = U_BEST;
          state_d   = stat_i.i_last ? S_EMIT : S_RD;
        end
      end
      S_TOT: begin
        cmd_o.uop = U_TOT;
        if (stat_i.tot_last) begin
          state_d = S_EMIT;
        end
      end
      S_SRD0: begin
        cmd_o.uop = U_RD;
        state_d   = S_SLD;
      end
      S_SLD: begin
        cmd_o.uop = U_LDC;
        state_d   = S_SRDJ;
      end
      S_SRDJ: begin
        cmd_o.uop = U_RD;
        state_d   = S_SSW;
      end
      S_SSW: begin
        cmd_o.uop = U_SW;
        state_d   = stat_i.i_at_end ? S_SWE : S_SRDJ;
      end
      S_SWE: begin
        cmd_o.uop = U_WEND;
        state_d   = stat_i.end_one ? S_EMIT : S_SRD0;
      end
      S_RRD: begin
        cmd_o.uop = U_RD;
        state_d   = S_REM;
      end
      S_REM: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.i_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.uop = U_NEXT;
            state_d   = S_RRD;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/row_table_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the row table engine: stream ports, controller and datapath.
// Depends on rte_pkg, rte_ctrl and rte_datapath.
//
// The engine keeps NUM_ROWS rows of up to ROW_CAPACITY signed 32-bit values
// in one single-port-read memory and takes one item at a time. A column
// value is pushed to the row under the column cursor, and at column end the
// remaining rows are filled with the fill value. The table total adds up the
// row fill counts one row after another. Max and min read one cell and then
// compare it, cell after cell; search is the same but stops at the first
// hit. Sort is a bubble sort through the memory port. Read row gives one
// result per cell read. The pace of all operations is set by the one memory
// read port with its registered data; a stalled output adds its wait.
module row_table_engine_core #(
  parameter int NUM_ROWS     = 8,
  parameter int ROW_CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,   // fill_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row[2:0], value[34:3], zero pad
  input  logic [4:0]  s_axis_tuser,  // opcode[3:0], ascending[4]
  input  logic        s_axis_tlast,  // column_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // result_value[31:0], result_index[36:32],
                                     // element_count[45:37], zero pad
  output logic [1:0]  m_axis_tuser,  // found[0], status[1]
  output logic        m_axis_tlast   // final_item
);
  import rte_pkg::*;

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [31:0] result_value;
  logic [4:0]  result_index;
  logic [8:0]  element_count;
  logic        found, status;

  rte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rte_datapath #(
    .NUM_ROWS     (NUM_ROWS),
    .ROW_CAPACITY (ROW_CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (s_axis_tuser[3:0]),
    .row_i           (s_axis_tdata[2:0]),
    .value_i         (s_axis_tdata[34:3]),
    .column_end_i    (s_axis_tlast),
    .ascending_i     (s_axis_tuser[4]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .result_value_o  (result_value),
    .result_index_o  (result_index),
    .found_o         (found),
    .element_count_o (element_count),
    .status_o        (status),
    .final_item_o    (m_axis_tlast)
  );

  // Pack the result fields.
  assign m_axis_tdata = {2'b00, element_count, result_index, result_value};
  assign m_axis_tuser = {status, found};

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of row_table_engine_core: random and directed table operations.
// Depends on rte_pkg and the design files; an internal predictor checks every result item.
module tb_top;
  import rte_pkg::*;

  localparam int NROW = 8;
  localparam int CAP = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    op_e         op;
    logic [2:0]  row;
    logic [31:0] val;
    logic        cend;
    logic        asc;
  } table_op_t;

  typedef struct {
    logic [31:0] val;
    logic [4:0]  idx;
    logic        found;
    logic [8:0]  cnt;
    logic        status;
    logic        last;
  } table_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  row_table_engine_core #(.NUM_ROWS(NROW), .ROW_CAPACITY(CAP)) uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: a copy of the table, its fill counts and the column cursor.
  logic [31:0] tbl_cell[NROW][CAP];
  int          tbl_fill[NROW];
  int          col_cursor;
  logic [31:0] fill_reg;

  table_op_t   op_pending_q[$];
  table_res_t  result_q[$];
  table_op_t   cur_op;
  int          errors = 0;
  int          ops_accepted = 0;
  int          results_seen = 0;
  int          drops_seen = 0;
  int          idle_cycles = 0;

  function automatic logic store_cell(int r, logic [31:0] v);
    if (tbl_fill[r] >= CAP) return 1'b1;
    tbl_cell[r][tbl_fill[r]] = v;
    tbl_fill[r]++;
    return 1'b0;
  endfunction

  // Work out the result items of one accepted item and queue them.
  function automatic void predict_table_op(table_op_t t);
    table_res_t rs;
    int n;
    int r;
    int i;
    int j;
    logic [31:0] best;
    logic [31:0] key;
    logic st;
    r = t.row;
    n = tbl_fill[r];
    rs = '{val: '0, idx: '0, found: 1'b0, cnt: '0, status: 1'b0, last: 1'b1};
    case (t.op)
      OP_APPEND: rs.status = store_cell(r, t.val);
      OP_COLUMN: begin
        st = 1'b0;
        if (col_cursor < NROW) begin
          st |= store_cell(col_cursor, t.val);
          col_cursor++;
        end
        if (t.cend) begin
          for (i = col_cursor; i < NROW; i++) st |= store_cell(i, fill_reg);
          col_cursor = 0;
        end
        rs.status = st;
      end
      OP_MAX, OP_MIN: begin
        best = '0;
        if (n > 0) best = tbl_cell[r][0];
        for (i = 1; i < n; i++) begin
          if (t.op == OP_MAX ? ($signed(tbl_cell[r][i]) > $signed(best))
                             : ($signed(tbl_cell[r][i]) < $signed(best)))
            best = tbl_cell[r][i];
        end
        rs.val = best;
      end
      OP_SEARCH: begin
        for (i = 0; i < n; i++) begin
          if (!rs.found && tbl_cell[r][i] == t.val) begin
            rs.found = 1'b1;
            rs.idx = i[4:0];
          end
        end
      end
      OP_COUNT: rs.cnt = n[8:0];
      OP_TOTAL: begin
        j = 0;
        for (i = 0; i < NROW; i++) j += tbl_fill[i];
        rs.cnt = j[8:0];
      end
      OP_SORT: begin
        // Insertion sort; equal keys are interchangeable, so any order method agrees.
        for (i = 1; i < n; i++) begin
          key = tbl_cell[r][i];
          j = i;
          while (j > 0 && (t.asc ? ($signed(key) < $signed(tbl_cell[r][j-1]))
                                 : ($signed(key) > $signed(tbl_cell[r][j-1])))) begin
            tbl_cell[r][j] = tbl_cell[r][j-1];
            j--;
          end
          tbl_cell[r][j] = key;
        end
      end
      OP_READ: begin
        if (n > 0) begin
          for (i = 0; i < n; i++) begin
            rs.val = tbl_cell[r][i];
            rs.found = 1'b1;
            rs.last = (i == n - 1);
            result_q.push_back(rs);
          end
          return;
        end
      end
      default: return;
    endcase
    result_q.push_back(rs);
  endfunction

  // Driver: sends queued items in bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_table_op(cur_op);
        ops_accepted++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (op_pending_q.size() > 0) begin
          cur_op = op_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, cur_op.val, cur_op.row};
          s_axis_tuser <= {cur_op.asc, cur_op.op};
          s_axis_tlast <= cur_op.cend;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern with a randomly chosen mode, plus one long hold-off.
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
      if (!hold_done && ops_accepted >= 60) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: each accepted result item is compared with the oldest expectation.
  table_res_t got;
  table_res_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = '{val: m_axis_tdata[31:0], idx: m_axis_tdata[36:32],
              found: m_axis_tuser[0], cnt: m_axis_tdata[45:37],
              status: m_axis_tuser[1], last: m_axis_tlast};
      if (got.status) drops_seen++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result item val=%h idx=%0d found=%b cnt=%0d st=%b last=%b",
                 $time, got.val, got.idx, got.found, got.cnt, got.status, got.last);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.val !== want.val) begin
          $display("%0t: result_value expected %h actual %h", $time, want.val, got.val);
          errors++;
        end
        if (got.idx !== want.idx) begin
          $display("%0t: result_index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, got.found);
          errors++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: element_count expected %0d actual %0d", $time, want.cnt, got.cnt);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, got.status);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: final_item expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: timeout, %0d result items still expected", $time, result_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  int ops_queued = 0;

  task automatic queue_op(op_e op, int row, logic [31:0] val, logic cend = 1'b0,
                          logic asc = 1'b0);
    table_op_t t;
    t = '{op: op, row: row[2:0], val: val, cend: cend, asc: asc};
    op_pending_q.push_back(t);
    ops_queued++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return $urandom();
      default: return $urandom_range(0, 9) - 4;
    endcase
  endfunction

  // Sender pause: wait until the pending items and expected results are gone.
  task automatic wait_drained();
    while (op_pending_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
      @(posedge clk_i);
    // A reserved opcode gives no result, so let the block settle.
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_fill(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    fill_reg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random sequence: mostly well-formed append and column runs with queries.
  task automatic queue_random_seq();
    int len;
    int r;
    int k;
    r = $urandom_range(0, NROW - 1);
    case ($urandom_range(0, 9))
      0, 1: begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          queue_op(OP_APPEND, r, pick_value(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
      2, 3: begin
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++)
          queue_op(OP_COLUMN, r, pick_value(), k == len - 1 && $urandom_range(0, 7) != 0,
                   1'($urandom_range(0, 1)));
      end
      4: begin
        queue_op(OP_SORT, r, pick_value(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        queue_op(OP_READ, r, pick_value(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end
      5: queue_op(op_e'($urandom_range(9, 15)), r, $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      default: queue_op(op_e'($urandom_range(2, 8)), r, pick_value(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  initial begin
    int k;
    int phase;
    logic [31:0] fills[4];
    foreach (tbl_fill[k]) tbl_fill[k] = 0;
    col_cursor = 0;
    fill_reg = FILL_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, empty rows and column fill.
    queue_op(OP_MAX, 7, 0);
    queue_op(OP_MIN, 7, 0);
    queue_op(OP_SEARCH, 7, 0);
    queue_op(OP_SORT, 7, 0, 1'b0, 1'b1);
    queue_op(OP_READ, 7, 0);
    queue_op(OP_APPEND, 1, 32'h7fff_ffff);
    queue_op(OP_APPEND, 1, 32'h8000_0000);
    queue_op(OP_APPEND, 1, 32'hffff_ffff);
    queue_op(OP_APPEND, 1, 32'd0);
    queue_op(OP_MAX, 1, 0);
    queue_op(OP_MIN, 1, 0);
    queue_op(OP_SEARCH, 1, 32'hffff_ffff);
    queue_op(OP_SEARCH, 1, 32'd5);
    queue_op(OP_COUNT, 1, 0);
    queue_op(OP_SORT, 1, 0, 1'b0, 1'b1);
    queue_op(OP_READ, 1, 0);
    queue_op(OP_SORT, 1, 0, 1'b1, 1'b0);
    queue_op(OP_READ, 1, 0);
    queue_op(OP_RSV9, 2, 32'h1234);
    queue_op(OP_RSV15, 5, 32'hffff_ffff, 1'b1, 1'b1);
    queue_op(OP_COLUMN, 0, 32'd11);
    queue_op(OP_COLUMN, 0, 32'd12, 1'b1);
    queue_op(OP_TOTAL, 0, 0);
    wait_drained();

    fills = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, $urandom()};
    for (phase = 0; phase < 4; phase++) begin
      write_fill(fills[phase]);
      // Overflowing column: more values than rows, then the end mark.
      if (phase == 0) begin
        for (k = 0; k < 10; k++) queue_op(OP_COLUMN, 0, pick_value(), k == 9);
      end
      // Fill one row past its capacity so appends are dropped.
      if (phase == 1) begin
        for (k = 0; k < 34; k++) queue_op(OP_APPEND, 3, pick_value());
        queue_op(OP_SORT, 3, 0, 1'b0, 1'b1);
        queue_op(OP_READ, 3, 0);
      end
      while (ops_queued < 23 + 72 * (phase + 1)) queue_random_seq();
      wait_drained();
    end

    $display("Covered %0d accepted items and %0d result items, %0d with a dropped append,",
             ops_accepted, results_seen, drops_seen);
    $display("over five fill settings including both signed extremes.");
    if (errors == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d result items never seen", errors, result_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
